// File: sv/mbe_pkg.sv
`default_nettype none

package mbe_pkg;

    // Fixed formats of the datapath.
    localparam int VAL_W  = 32;            // signed complex parts
    localparam int MAG_W  = 40;            // unsigned squares and magnitude
    localparam int PROD_W = 2 * VAL_W;     // full multiplier product
    localparam int WIDE_W = PROD_W + 2;    // room for a product plus two addends
    localparam int REG_W  = 11;            // configuration register width

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_CAP     = 1'd1;

    localparam logic [REG_W-1:0] ESCAPE_LIMIT_RST = 11'd64;
    localparam logic [REG_W-1:0] ITER_CAP_RST     = 11'd256;

    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic [MAG_W-1:0]         t_mag;

    // Saturates a wide signed value to the signed complex-part range.
    function automatic t_val sat_val(input t_wide v);
        t_val res;
        if (!v[WIDE_W-1] && (|v[WIDE_W-2:VAL_W-1])) begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (v[WIDE_W-1] && !(&v[WIDE_W-2:VAL_W-1])) begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: sv/mbe_in_if.sv
`default_nettype none

interface mbe_in_if;
    logic                  valid;
    logic                  ready;
    mbe_pkg::t_val         coord_x;
    mbe_pkg::t_val         coord_y;
    mbe_pkg::t_val         zoom_scale;

    modport source (output valid, output coord_x, output coord_y, output zoom_scale,
                    input ready);
    modport sink   (input valid, input coord_x, input coord_y, input zoom_scale,
                    output ready);
endinterface

`default_nettype wire

// File: sv/mbe_out_if.sv
`default_nettype none

interface mbe_out_if #(
    parameter int COUNT_WIDTH = 11
);
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] iteration_count;
    mbe_pkg::t_mag          final_mag_sq;
    logic                   is_black;

    modport source (output valid, output iteration_count, output final_mag_sq,
                    output is_black, input ready);
    modport sink   (input valid, input iteration_count, input final_mag_sq,
                    input is_black, output ready);
endinterface

`default_nettype wire

// File: sv/mandelbrot_escape_time.sv
// Mandelbrot escape-time core.
// Items arrive on i_in (coord_x, coord_y, zoom_scale, signed Q8.24) with a
// valid/ready handshake; each item gives exactly one result item on o_out
// (iteration_count, final_mag_sq in unsigned Q16.24, is_black).
// escape_limit (index 0) and max_iterations (index 1) are written through
// i_cfg_we / i_cfg_idx / i_cfg_data. The user must write them only while
// the core is idle; the core itself does not enforce it.
// All products go through one 32x32 signed multiplier. c is set up first
// (states S_CX, S_CY, S_C2); each iteration then runs three multiplier
// passes: re*im, then, after the update of re and im, re*re and im*im,
// followed by one magnitude sum and one escape compare. i_in.ready stays
// low from acceptance until the result is loaded and the core is idle.
// A finished result sits in an output register, so the next item is taken
// while the receiver stalls; a second result waits in the finishing state
// until the output register is free.
// Synchronous reset returns to idle, drops o_out.valid and loads the
// registers with escape_limit 64 and max_iterations 256.
`default_nettype none

module mandelbrot_escape_time #(
    parameter int FRAC_BITS   = 24,
    parameter int COUNT_WIDTH = 11
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    mbe_in_if.sink                           i_in,
    mbe_out_if.source                        o_out,
    input  wire                              i_cfg_we,
    input  wire [mbe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [mbe_pkg::REG_W-1:0]         i_cfg_data
);

    localparam int LIM_W   = mbe_pkg::REG_W + FRAC_BITS;
    localparam int CMP_W   = (mbe_pkg::MAG_W > LIM_W) ? mbe_pkg::MAG_W + 1 : LIM_W + 1;
    localparam int CNT_EXT = (COUNT_WIDTH > mbe_pkg::REG_W) ? COUNT_WIDTH : mbe_pkg::REG_W;
    localparam logic [CMP_W-1:0] ONE = CMP_W'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_CX, S_CY, S_C2, S_MRI, S_UPD, S_SRE, S_SIM, S_MAG, S_CHK, S_FIN
    } t_state;

    t_state                             r_state;
    logic [mbe_pkg::REG_W-1:0]          r_escape_limit;
    logic [mbe_pkg::REG_W-1:0]          r_iter_cap;
    mbe_pkg::t_val                      r_x, r_y, r_s;
    mbe_pkg::t_val                      r_re_c, r_im_c, r_re, r_im;
    mbe_pkg::t_mag                      r_re2, r_im2, r_mag;
    logic [mbe_pkg::REG_W-1:0]          r_iter;
    logic signed [mbe_pkg::PROD_W-1:0]  r_prod;
    logic                               r_out_valid;
    logic [mbe_pkg::REG_W-1:0]          r_out_cnt;
    mbe_pkg::t_mag                      r_out_mag;
    logic                               r_out_black;

    mbe_pkg::t_val                      mul_a, mul_b;
    logic [mbe_pkg::PROD_W-1:0]         sq_shift;
    mbe_pkg::t_mag                      sq_now;
    logic [mbe_pkg::MAG_W:0]            mag_sum;
    mbe_pkg::t_mag                      mag_sat;
    mbe_pkg::t_wide                     c_wide, im_wide, re_wide;
    logic [CMP_W-1:0]                   limit_cmp, mag_cmp;
    logic [mbe_pkg::REG_W:0]            n_iter;
    logic                               out_free;
    logic [CNT_EXT-1:0]                 cnt_ext;

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (r_state)
            S_CY:    begin mul_a = r_y;  mul_b = r_s;  end
            S_MRI:   begin mul_a = r_re; mul_b = r_im; end
            S_SRE:   begin mul_a = r_re; mul_b = r_re; end
            S_SIM:   begin mul_a = r_im; mul_b = r_im; end
            default: begin mul_a = r_x;  mul_b = r_s;  end
        endcase
    end

    always_comb begin
        // A square is never negative, so a logical shift gives the floor.
        sq_shift  = $unsigned(r_prod) >> FRAC_BITS;
        sq_now    = (|sq_shift[mbe_pkg::PROD_W-1:mbe_pkg::MAG_W]) ? mbe_pkg::MAG_MAX
                                                                  : sq_shift[mbe_pkg::MAG_W-1:0];
        mag_sum   = {1'b0, r_re2} + {1'b0, sq_now};
        mag_sat   = mag_sum[mbe_pkg::MAG_W] ? mbe_pkg::MAG_MAX : mag_sum[mbe_pkg::MAG_W-1:0];
        c_wide    = mbe_pkg::WIDE_W'(r_prod >>> (FRAC_BITS - 1));
        im_wide   = c_wide + mbe_pkg::WIDE_W'(r_im_c);
        re_wide   = mbe_pkg::WIDE_W'($signed({1'b0, r_re2}))
                  - mbe_pkg::WIDE_W'($signed({1'b0, r_im2}))
                  + mbe_pkg::WIDE_W'(r_re_c);
        limit_cmp = CMP_W'(r_escape_limit) << FRAC_BITS;
        mag_cmp   = CMP_W'(r_mag);
        n_iter    = {1'b0, r_iter} + 1'b1;
        out_free  = !r_out_valid || o_out.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape_limit <= mbe_pkg::ESCAPE_LIMIT_RST;
            r_iter_cap     <= mbe_pkg::ITER_CAP_RST;
        end else if (i_cfg_we) begin
            priority if (i_cfg_idx == mbe_pkg::CFG_ESCAPE_LIMIT) begin
                r_escape_limit <= i_cfg_data;
            end else if (i_cfg_idx == mbe_pkg::CFG_ITER_CAP) begin
                r_iter_cap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_x     <= i_in.coord_x;
                        r_y     <= i_in.coord_y;
                        r_s     <= i_in.zoom_scale;
                        r_state <= S_CX;
                    end
                end
                S_CX: r_state <= S_CY;
                S_CY: begin
                    r_re_c  <= mbe_pkg::sat_val(c_wide);
                    r_state <= S_C2;
                end
                S_C2: begin
                    r_im_c <= mbe_pkg::sat_val(c_wide);
                    r_re   <= '0;
                    r_im   <= '0;
                    r_re2  <= '0;
                    r_im2  <= '0;
                    r_mag  <= '0;
                    r_iter <= '0;
                    r_state <= (r_iter_cap == '0) ? S_FIN : S_MRI;
                end
                S_MRI: r_state <= S_UPD;
                S_UPD: begin
                    r_im    <= mbe_pkg::sat_val(im_wide);
                    r_re    <= mbe_pkg::sat_val(re_wide);
                    r_state <= S_SRE;
                end
                S_SRE: r_state <= S_SIM;
                S_SIM: begin
                    r_re2   <= sq_now;
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_im2   <= sq_now;
                    r_mag   <= mag_sat;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // On escape the count stays at the step just run.
                    if (mag_cmp > limit_cmp) begin
                        r_state <= S_FIN;
                    end else begin
                        r_iter  <= n_iter[mbe_pkg::REG_W-1:0];
                        r_state <= (n_iter == {1'b0, r_iter_cap}) ? S_FIN : S_MRI;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_cnt   <= r_iter;
                        r_out_mag   <= r_mag;
                        r_out_black <= (r_iter == r_iter_cap) || (mag_cmp <= ONE);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign cnt_ext               = CNT_EXT'(r_out_cnt);
    assign i_in.ready            = (r_state == S_IDLE);
    assign o_out.valid           = r_out_valid;
    assign o_out.iteration_count = cnt_ext[COUNT_WIDTH-1:0];
    assign o_out.final_mag_sq    = r_out_mag;
    assign o_out.is_black        = r_out_black;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_state == S_CX)
        else $error("accepted item did not start the setup sequence");

    a_mag_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MAG |=> r_state == S_CHK)
        else $error("magnitude update not followed by escape check");

    a_small_is_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.is_black |-> CMP_W'(o_out.final_mag_sq) > ONE)
        else $error("result with modulus at most one not flagged black");

    a_fin_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FIN && out_free |=> o_out.valid && r_state == S_IDLE)
        else $error("finished result not loaded into the output register");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC           = 24;
    localparam int COUNT_W        = 11;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_OFF       = 400;

    localparam mbe_pkg::t_val VMAX = 32'sh7FFF_FFFF;
    localparam mbe_pkg::t_val VMIN = 32'sh8000_0000;
    localparam mbe_pkg::t_val ONE  = 32'sh0100_0000;
    localparam mbe_pkg::t_val HALF = 32'sh0080_0000;

    typedef struct {
        int                   seq;
        logic [COUNT_W-1:0]   count;
        mbe_pkg::t_mag        mag;
        logic                 black;
    } t_escape;

    class escape_scoreboard;
        t_escape                   expected_q[$];
        logic [mbe_pkg::REG_W-1:0] escape_limit;
        logic [mbe_pkg::REG_W-1:0] iter_cap;
        int                        points;
        int                        checked;
        int                        mismatches;

        function new();
            escape_limit = mbe_pkg::ESCAPE_LIMIT_RST;
            iter_cap     = mbe_pkg::ITER_CAP_RST;
            points       = 0;
            checked      = 0;
            mismatches   = 0;
        endfunction

        function void set_config(input logic [mbe_pkg::REG_W-1:0] limit,
                                 input logic [mbe_pkg::REG_W-1:0] cap);
            escape_limit = limit;
            iter_cap     = cap;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function longint clamp_val(input longint v);
            if (v > longint'(VMAX)) return longint'(VMAX);
            if (v < longint'(VMIN)) return longint'(VMIN);
            return v;
        endfunction

        function longint square_q(input longint v);
            longint sq;
            sq = (v * v) >>> FRAC;
            return (sq > longint'(mbe_pkg::MAG_MAX)) ? longint'(mbe_pkg::MAG_MAX) : sq;
        endfunction

        // Products are floored by the arithmetic shift; the factor of two in
        // 2*x*scale and 2*re*im is folded into a shift one bit shorter.
        function t_escape escape_time(input mbe_pkg::t_val x, input mbe_pkg::t_val y,
                                      input mbe_pkg::t_val s);
            longint      re_c;
            longint      im_c;
            longint      re;
            longint      im;
            longint      next_im;
            longint      re_sq;
            longint      im_sq;
            longint      mag_sum;
            longint      bound;
            int unsigned step;
            t_escape     res;
            re_c    = clamp_val((longint'(x) * longint'(s)) >>> (FRAC - 1));
            im_c    = clamp_val((longint'(y) * longint'(s)) >>> (FRAC - 1));
            re      = 0;
            im      = 0;
            re_sq   = 0;
            im_sq   = 0;
            mag_sum = 0;
            bound   = longint'(escape_limit) << FRAC;
            for (step = 0; step < iter_cap; step++) begin
                next_im = clamp_val(((re * im) >>> (FRAC - 1)) + im_c);
                re      = clamp_val(re_sq - im_sq + re_c);
                im      = next_im;
                re_sq   = square_q(re);
                im_sq   = square_q(im);
                mag_sum = re_sq + im_sq;
                if (mag_sum > longint'(mbe_pkg::MAG_MAX)) mag_sum = longint'(mbe_pkg::MAG_MAX);
                if (mag_sum > bound) break;
            end
            res.seq   = points;
            res.count = step[COUNT_W-1:0];
            res.mag   = mag_sum[mbe_pkg::MAG_W-1:0];
            res.black = (step == iter_cap) || (mag_sum <= (longint'(1) << FRAC));
            return res;
        endfunction

        function void note_point(input mbe_pkg::t_val x, input mbe_pkg::t_val y,
                                 input mbe_pkg::t_val s);
            expected_q.push_back(escape_time(x, y, s));
            points++;
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task check_result(input logic [COUNT_W-1:0] count, input mbe_pkg::t_mag mag,
                          input logic black);
            t_escape want;
            if (expected_q.size() == 0) begin
                report_mismatch("result arrived with no point outstanding");
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (count !== want.count)
                report_mismatch($sformatf("point %0d: iteration_count %0d, expected %0d",
                                          want.seq, count, want.count));
            if (mag !== want.mag)
                report_mismatch($sformatf("point %0d: final_mag_sq %h, expected %h",
                                          want.seq, mag, want.mag));
            if (black !== want.black)
                report_mismatch($sformatf("point %0d: is_black %b, expected %b",
                                          want.seq, black, want.black));
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we;
    logic [mbe_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [mbe_pkg::REG_W-1:0]     i_cfg_data;

    mbe_in_if                           in_ch ();
    mbe_out_if #(.COUNT_WIDTH(COUNT_W)) out_ch ();

    mandelbrot_escape_time #(
        .FRAC_BITS   (FRAC),
        .COUNT_WIDTH (COUNT_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    escape_scoreboard sb;
    bit               rx_idle;
    int               hold_cycles;
    int               quiet_cycles;
    int               n_settings;
    mbe_pkg::t_val    directed_pts [20][3];

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
            sb.note_point(in_ch.coord_x, in_ch.coord_y, in_ch.zoom_scale);
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_result(out_ch.iteration_count, out_ch.final_mag_sq, out_ch.is_black);
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
                     quiet_cycles, sb.pending());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: a random stall before each item while rx_idle is set, or one long hold-off on request.
    initial begin : receiver
        int stall;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = rx_idle ? $urandom_range(0, 15) : 0;
            if (hold_cycles > 0) begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (out_ch.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    // All driving tasks start and end at a falling edge.
    task automatic send_point(input mbe_pkg::t_val x, input mbe_pkg::t_val y,
                              input mbe_pkg::t_val s, input bit idle);
        int gap;
        gap = idle ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.coord_x    <= x;
        in_ch.coord_y    <= y;
        in_ch.zoom_scale <= s;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_config(input int limit, input int cap);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= mbe_pkg::CFG_ESCAPE_LIMIT;
        i_cfg_data <= mbe_pkg::REG_W'(limit);
        @(negedge i_clk);
        i_cfg_idx  <= mbe_pkg::CFG_ITER_CAP;
        i_cfg_data <= mbe_pkg::REG_W'(cap);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_config(mbe_pkg::REG_W'(limit), mbe_pkg::REG_W'(cap));
        n_settings++;
    endtask

    // Most points land near the set with scale one half, so that c equals
    // the coordinates; the rest are scaled points and raw noise.
    task automatic pick_point(output mbe_pkg::t_val x, output mbe_pkg::t_val y,
                              output mbe_pkg::t_val s);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            x = int'($urandom_range(0, 45_000_000)) - 35_000_000;
            y = int'($urandom_range(0, 40_000_000)) - 20_000_000;
            s = HALF;
        end else if (sel < 85) begin
            x = int'($urandom_range(0, 67_108_864)) - 33_554_432;
            y = int'($urandom_range(0, 67_108_864)) - 33_554_432;
            s = int'($urandom_range(0, 33_554_432)) - 16_777_216;
        end else begin
            x = $urandom;
            y = $urandom;
            s = $urandom;
        end
    endtask

    task automatic run_phase(input int limit, input int cap, input int count, input int hold_at);
        mbe_pkg::t_val x;
        mbe_pkg::t_val y;
        mbe_pkg::t_val s;
        bit            idle;
        set_config(limit, cap);
        for (int k = 0; k < count; k++) begin
            idle    = ((k / 25) % 2) == 0;
            rx_idle = idle;
            if (k == hold_at) hold_cycles = HOLD_OFF;
            // The sender stops here until the block has returned everything.
            if (hold_at >= 0 && k == count / 2) wait_idle();
            pick_point(x, y, s);
            send_point(x, y, s, idle);
        end
        wait_idle();
    endtask

    task automatic run_directed();
        directed_pts = '{
            '{0, 0, 0},
            '{VMAX, VMAX, VMAX},
            '{VMIN, VMIN, VMIN},
            '{VMIN, VMAX, VMIN},
            '{VMAX, VMIN, -1},
            '{-1, -1, -1},
            '{-1, 1, 1},
            '{-16_777_216, 0, HALF},
            '{4_194_304, 0, HALF},
            '{-33_554_432, 0, HALF},
            '{0, ONE, HALF},
            '{ONE, 0, HALF},
            '{-12_582_912, 1_677_722, HALF},
            '{ONE, ONE, ONE},
            '{0, 0, VMAX},
            '{VMAX, 0, ONE},
            '{5_033_165, 0, HALF},
            '{-1_677_722, 10_905_190, HALF},
            '{0, VMIN, HALF},
            '{VMIN, 0, VMIN}
        };
        rx_idle = 1'b1;
        foreach (directed_pts[i])
            send_point(directed_pts[i][0], directed_pts[i][1], directed_pts[i][2], 1'b1);
        wait_idle();
    endtask

    initial begin
        sb               = new();
        rx_idle          = 1'b1;
        hold_cycles      = 0;
        quiet_cycles     = 0;
        n_settings       = 1;
        in_ch.valid      = 1'b0;
        in_ch.coord_x    = '0;
        in_ch.coord_y    = '0;
        in_ch.zoom_scale = '0;
        out_ch.ready     = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = mbe_pkg::CFG_ESCAPE_LIMIT;
        i_cfg_data       = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset values first, then low, high and zero register settings and some in between.
        run_directed();
        run_phase(1, 1, 40, -1);
        run_phase(4, 32, 150, 30);
        run_phase(1024, 1024, 8, -1);
        run_phase(0, 0, 10, -1);
        run_phase(0, 16, 30, -1);
        run_phase(2, 64, 120, -1);
        run_phase(16, 128, 100, -1);
        run_phase(1024, 8, 40, -1);

        repeat (100) @(posedge i_clk);
        $display("Sent %0d points under %0d register settings, zero and full-scale included.",
                 sb.points, n_settings);
        $display("Compared %0d results, %0d mismatches.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
